// ===== hw/rtl/four_channel_compare_alarm_timer_assert.svh =====
// ----------------------------------------------------------------------------
// four_channel_compare_alarm_timer_assert.svh
// Assertion macros shared by the alarm timer checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_COMPARE_ALARM_TIMER_ASSERT_SVH
`define FOUR_CHANNEL_COMPARE_ALARM_TIMER_ASSERT_SVH

// Clocked property on clock, masked while reset is high.
`define FCAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication on clock, masked while reset is high.
`define FCAT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fcat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcat_pkg
// Request/response types and command codes for the compare alarm timer.
// ----------------------------------------------------------------------------
package fcat_pkg;

   localparam int PRESCALE_BITS = 16;
   localparam int FIELD_BITS    = 32;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SET_REL = 2'd1,
      CMD_SET_ABS = 2'd2,
      CMD_CANCEL  = 2'd3
   } command_type;

   typedef struct packed {
      command_type                   command;
      logic [1:0]                    channel;
      logic signed [FIELD_BITS-1:0]  time_value;
      logic signed [FIELD_BITS-1:0]  alarm_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]                    fired_channel;
      logic signed [FIELD_BITS-1:0]  fired_tag;
      logic [FIELD_BITS-1:0]         fire_count;
   } rsp_type;

endpackage

// ===== hw/rtl/fcat_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcat_counter
// Tick prescaler and free-running microsecond count.
// ----------------------------------------------------------------------------
module fcat_counter #(
   parameter int COUNT_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic                                  is_tick,
   input  logic [fcat_pkg::PRESCALE_BITS-1:0]    prescale_divide,
   output logic                                  advance,
   output logic [COUNT_BITS-1:0]                 count_cur,
   output logic [COUNT_BITS-1:0]                 count_new
);
   import fcat_pkg::*;

   logic [PRESCALE_BITS-1:0] pre_ff, pre_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   // divider lowered below running count still advances on next tick
   assign advance   = is_tick && (pre_ff >= prescale_divide);
   assign count_cur = count_ff;
   assign count_new = advance ? count_ff + 1'b1 : count_ff;

   always_comb begin
      pre_in   = pre_ff;
      count_in = count_ff;
      if (step && is_tick) begin
         pre_in   = advance ? '0 : pre_ff + 1'b1;
         count_in = count_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff   <= '0;
         count_ff <= '0;
      end else begin
         pre_ff   <= pre_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hw/rtl/fcat_alarms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcat_alarms
// Alarm bank: arm/cancel, compare on count advance, lowest-channel pick.
// ----------------------------------------------------------------------------
module fcat_alarms #(
   parameter int NUM_ALARMS = 4,
   parameter int COUNT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  fcat_pkg::req_type                   req,
   input  logic                                advance,
   input  logic [COUNT_BITS-1:0]               count_cur,
   input  logic [COUNT_BITS-1:0]               count_new,
   output logic                                fire,
   output logic [1:0]                          fire_channel,
   output logic [fcat_pkg::FIELD_BITS-1:0]     fire_tag
);
   import fcat_pkg::*;

   logic [NUM_ALARMS-1:0]   en_ff, en_in, pend_ff, pend_in;
   logic [NUM_ALARMS-1:0]   en_mid, pend_mid;
   logic [COUNT_BITS-1:0]   cmp_ff [NUM_ALARMS];
   logic [COUNT_BITS-1:0]   cmp_in [NUM_ALARMS];
   logic [FIELD_BITS-1:0]   tag_ff [NUM_ALARMS];
   logic [FIELD_BITS-1:0]   tag_in [NUM_ALARMS];
   logic [COUNT_BITS-1:0]   rel_when;
   logic                    is_arm;

   assign rel_when = count_cur + req.time_value[COUNT_BITS-1:0];
   assign is_arm   = (req.command == CMD_SET_REL) || (req.command == CMD_SET_ABS);

   // per-channel state after the command
   always_comb begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
         en_mid[i]   = en_ff[i];
         pend_mid[i] = pend_ff[i];
         cmp_in[i]   = cmp_ff[i];
         tag_in[i]   = tag_ff[i];
         if (req.command == CMD_TICK) begin
            if (advance && (cmp_ff[i] == count_new)) begin
               pend_mid[i] = 1'b1;
            end
         end else if ({30'd0, req.channel} == 32'(i)) begin
            pend_mid[i] = 1'b0;
            en_mid[i]   = is_arm;
            if (is_arm) begin
               cmp_in[i] = (req.command == CMD_SET_REL) ? rel_when
                                                       : req.time_value[COUNT_BITS-1:0];
               tag_in[i] = req.alarm_tag;
            end
         end
      end
   end

   // lowest enabled pending channel fires and is disarmed
   always_comb begin
      fire         = 1'b0;
      fire_channel = '0;
      fire_tag     = '0;
      en_in        = en_mid;
      pend_in      = pend_mid;
      for (int i = 0; i < NUM_ALARMS; i++) begin
         if (!fire && en_mid[i] && pend_mid[i]) begin
            fire         = 1'b1;
            fire_channel = 2'(i);
            fire_tag     = tag_in[i];
            en_in[i]     = 1'b0;
            pend_in[i]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= '0;
         pend_ff <= '0;
         for (int i = 0; i < NUM_ALARMS; i++) begin
            cmp_ff[i] <= '0;
            tag_ff[i] <= '0;
         end
      end else if (step) begin
         en_ff   <= en_in;
         pend_ff <= pend_in;
         for (int i = 0; i < NUM_ALARMS; i++) begin
            cmp_ff[i] <= cmp_in[i];
            tag_ff[i] <= tag_in[i];
         end
      end
   end

endmodule

// ===== hw/rtl/four_channel_compare_alarm_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_compare_alarm_timer
// Prescaled microsecond counter with one-shot compare alarms.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload            | handshake
//   --------+-----------+--------------------+-----------------------
//   req     | in        | fcat_pkg::req_type | req_valid / req_ready
//   rsp     | out       | fcat_pkg::rsp_type | rsp_valid / rsp_ready
//   csr     | in        | prescale_divide    | csr_valid / csr_ready
//
// One request per clock unless a stalled response holds the input register. A
// request is accepted into the input register, is executed there (count,
// compares, priority pick) and any fired alarm lands in the output register.
// A stalled response blocks the input register only when the request held
// there would fire too; otherwise requests keep flowing.
// Synchronous active-high reset clears the count, prescaler and all alarms.
// ----------------------------------------------------------------------------
module four_channel_compare_alarm_timer #(
   parameter int NUM_ALARMS = 4,
   parameter int COUNT_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fcat_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fcat_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fcat_pkg::PRESCALE_BITS-1:0] csr_data
);
   import fcat_pkg::*;

   // prescale divider register
   logic [PRESCALE_BITS-1:0] divide_ff, divide_in;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                  go;
   logic                  advance;
   logic [COUNT_BITS-1:0] count_cur, count_new;
   logic                  fire;
   logic [1:0]            fire_channel;
   logic [FIELD_BITS-1:0] fire_tag;

   assign csr_ready = 1'b1;
   assign divide_in = csr_valid ? csr_data : divide_ff;

   // execute the held request when its result (if any) has somewhere to go
   assign go        = s1_valid_ff && (!rsp_valid_ff || rsp_ready || !fire);
   assign req_ready = !s1_valid_ff || go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_data;
      end
   end

   fcat_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock           (clock),
      .reset           (reset),
      .step            (go),
      .is_tick         (s1_req_ff.command == CMD_TICK),
      .prescale_divide (divide_ff),
      .advance         (advance),
      .count_cur       (count_cur),
      .count_new       (count_new)
   );

   fcat_alarms #(
      .NUM_ALARMS (NUM_ALARMS),
      .COUNT_BITS (COUNT_BITS)
   ) u_alarms (
      .clock        (clock),
      .reset        (reset),
      .step         (go),
      .req          (s1_req_ff),
      .advance      (advance),
      .count_cur    (count_cur),
      .count_new    (count_new),
      .fire         (fire),
      .fire_channel (fire_channel),
      .fire_tag     (fire_tag)
   );

   // response register: load on a firing step, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (go && fire) begin
         rsp_valid_in         = 1'b1;
         rsp_in.fired_channel = fire_channel;
         rsp_in.fired_tag     = fire_tag;
         rsp_in.fire_count    = 32'(count_new);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divide_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         divide_ff    <= divide_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== hw/rtl/fcat_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcat_checker
// Port-level checks for the alarm timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_channel_compare_alarm_timer_assert.svh"

module fcat_checker #(
   parameter int NUM_ALARMS = 4,
   parameter int COUNT_BITS = 32
) (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fcat_pkg::rsp_type rsp_data,
   input logic              csr_ready
);
   import fcat_pkg::*;

   logic        rsp_wait;
   logic [7:0]  chan_num;
   logic [63:0] count_top;

   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign chan_num  = 8'(rsp_data.fired_channel);
   assign count_top = 64'(rsp_data.fire_count) >> COUNT_BITS;

   // stalled response holds
   `FCAT_ASSERT_IMPL(a_rsp_hold, $past(rsp_wait), rsp_valid && $stable(rsp_data), "held rsp moved")

   // with the output register empty a request is always taken
   `FCAT_ASSERT_IMPL(a_req_flow, !rsp_valid, req_ready, "request stalled with empty output")

   // reported channel exists
   `FCAT_ASSERT_IMPL(a_chan_range, rsp_valid, chan_num < 8'(NUM_ALARMS), "fired channel out of range")

   // count never exceeds its width
   `FCAT_ASSERT_IMPL(a_count_width, rsp_valid, count_top == 64'd0, "fire count exceeds count width")

   // register port never stalls
   `FCAT_ASSERT(a_csr_ready, csr_ready, "register port stalled")

endmodule

bind four_channel_compare_alarm_timer fcat_checker #(
   .NUM_ALARMS (NUM_ALARMS),
   .COUNT_BITS (COUNT_BITS)
) u_fcat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
